// ----- rtl/plec_pkg.sv -----
// Shared types and constants for the positional list engine.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none
package plec_pkg;

   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 8;
   localparam int REQ_W    = 3;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   typedef enum logic [REQ_W-1:0] {
      REQ_INS_FRONT = 3'd0,
      REQ_INS_END   = 3'd1,
      REQ_INS_POS   = 3'd2,
      REQ_DEL_FRONT = 3'd3,
      REQ_DEL_END   = 3'd4,
      REQ_DEL_POS   = 3'd5,
      REQ_READ_ALL  = 3'd6
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_BADPOS = 2'd2,
      STAT_FULL   = 2'd3
   } status_type;

   // What a cell loads on the next edge
   typedef enum logic [2:0] {
      SEL_HOLD  = 3'd0,
      SEL_LEFT  = 3'd1,
      SEL_RIGHT = 3'd2,
      SEL_NEW   = 3'd3,
      SEL_HEAD  = 3'd4
   } sel_type;

   typedef struct packed {
      logic                     strobe;
      status_type               status;
      logic signed [DATA_W-1:0] value;
      logic [COUNT_W-1:0]       count;
      logic                     last;
   } rsp_type;

endpackage
`default_nettype wire

// ----- rtl/plec_cell.sv -----
// One storage cell of the element chain: holds one list entry.
// Depends on plec_pkg.
`default_nettype none
module plec_cell (
   input  wire logic                              clock,
   input  wire plec_pkg::sel_type                 sel,
   input  wire logic signed [plec_pkg::DATA_W-1:0] left_value,
   input  wire logic signed [plec_pkg::DATA_W-1:0] right_value,
   input  wire logic signed [plec_pkg::DATA_W-1:0] new_value,
   input  wire logic signed [plec_pkg::DATA_W-1:0] head_value,
   output logic signed [plec_pkg::DATA_W-1:0]      value
);
   import plec_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   always_comb begin
      unique case (sel)
         SEL_LEFT:  value_in = left_value;
         SEL_RIGHT: value_in = right_value;
         SEL_NEW:   value_in = new_value;
         SEL_HEAD:  value_in = head_value;
         default:   value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire

// ----- rtl/plec_ctrl.sv -----
// Request decoder, fill count, read-out sequencer and result register.
// Drives the per-cell load selects of the chain. Depends on plec_pkg.
`default_nettype none
module plec_ctrl (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire logic [plec_pkg::REQ_W-1:0]         req_type,
   input  wire logic [plec_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [plec_pkg::DATA_W-1:0] head_value,
   output logic                                    busy,
   output plec_pkg::sel_type                       cell_sel [plec_pkg::CAPACITY],
   output plec_pkg::rsp_type                       rsp
);
   import plec_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   rsp_type            rsp_ff, rsp_in;

   logic               ins_mode, del_mode, rot_mode;
   logic [COUNT_W-1:0] tgt;
   logic               full;
   logic               ins_pos_ok, del_pos_ok;
   logic [POS_W:0]     pos_wide;
   logic [POS_W:0]     count_wide;
   logic [COUNT_W-1:0] pos_idx;
   logic [COUNT_W-1:0] last_idx;

   assign full       = (count_ff == COUNT_W'(CAPACITY));
   assign pos_wide   = {1'b0, req_position};
   assign count_wide = (POS_W + 1)'(count_ff);
   assign ins_pos_ok = (req_position != '0) && (pos_wide <= count_wide + 1'b1);
   assign del_pos_ok = (req_position != '0) && (pos_wide <= count_wide);
   assign pos_idx    = COUNT_W'(req_position - 1'b1);
   assign last_idx   = count_ff - 1'b1;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      ins_mode   = 1'b0;
      del_mode   = 1'b0;
      rot_mode   = 1'b0;
      tgt        = '0;
      rsp_in.strobe = 1'b0;
      rsp_in.status = STAT_OK;
      rsp_in.value  = '0;
      rsp_in.count  = count_ff;
      rsp_in.last   = 1'b1;

      if (state_ff == ST_READ) begin
         // stream the head out and rotate the occupied cells by one
         rot_mode      = 1'b1;
         rsp_in.strobe = 1'b1;
         rsp_in.value  = head_value;
         rsp_in.last   = (idx_ff == last_idx);
         idx_in        = idx_ff + 1'b1;
         if (idx_ff == last_idx) begin
            state_in = ST_IDLE;
         end
      end else if (accept) begin
         rsp_in.strobe = 1'b1;
         unique case (req_code_type'(req_type))
            REQ_INS_FRONT, REQ_INS_END: begin
               if (full) begin
                  rsp_in.status = STAT_FULL;
               end else begin
                  ins_mode = 1'b1;
                  tgt      = (req_code_type'(req_type) == REQ_INS_END) ? count_ff : '0;
               end
            end
            REQ_INS_POS: begin
               if (!ins_pos_ok) begin
                  rsp_in.status = STAT_BADPOS;
               end else if (full) begin
                  rsp_in.status = STAT_FULL;
               end else begin
                  ins_mode = 1'b1;
                  tgt      = pos_idx;
               end
            end
            REQ_DEL_FRONT, REQ_DEL_END: begin
               if (count_ff == '0) begin
                  rsp_in.status = STAT_EMPTY;
               end else begin
                  del_mode = 1'b1;
                  tgt      = (req_code_type'(req_type) == REQ_DEL_END) ? last_idx : '0;
               end
            end
            REQ_DEL_POS: begin
               if (count_ff == '0) begin
                  rsp_in.status = STAT_EMPTY;
               end else if (!del_pos_ok) begin
                  rsp_in.status = STAT_BADPOS;
               end else begin
                  del_mode = 1'b1;
                  tgt      = pos_idx;
               end
            end
            REQ_READ_ALL: begin
               if (count_ff == '0) begin
                  rsp_in.status = STAT_EMPTY;
               end else begin
                  // results come from the sequencer, one per element
                  rsp_in.strobe = 1'b0;
                  state_in      = ST_READ;
                  idx_in        = '0;
               end
            end
            default: begin
               rsp_in.status = STAT_OK;
            end
         endcase
         if (ins_mode) begin
            count_in     = count_ff + 1'b1;
            rsp_in.count = count_ff + 1'b1;
         end
         if (del_mode) begin
            count_in     = last_idx;
            rsp_in.count = last_idx;
         end
      end
   end

   // per-cell load selects, each cell decided on its own
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_sel[i] = SEL_HOLD;
         if (ins_mode) begin
            if (COUNT_W'(i) == tgt) begin
               cell_sel[i] = SEL_NEW;
            end else if (COUNT_W'(i) > tgt && COUNT_W'(i) <= count_ff) begin
               cell_sel[i] = SEL_LEFT;
            end
         end else if (del_mode) begin
            if (COUNT_W'(i) >= tgt && COUNT_W'(i) < last_idx) begin
               cell_sel[i] = SEL_RIGHT;
            end
         end else if (rot_mode) begin
            if (COUNT_W'(i) < last_idx) begin
               cell_sel[i] = SEL_RIGHT;
            end else if (COUNT_W'(i) == last_idx) begin
               cell_sel[i] = SEL_HEAD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         rsp_ff.strobe <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign busy = (state_ff == ST_READ);
   assign rsp  = rsp_ff;

endmodule
`default_nettype wire

// ----- rtl/positional_list_engine_unit.sv -----
// Top level of the positional list engine: controller plus a chain of cells.
// Depends on plec_pkg, plec_cell and plec_ctrl.
`default_nettype none
// Bounded ordered list of up to 16 signed 32-bit values, held in a row of
// cells with the front in cell 0. A transaction is taken at a rising edge with
// start high and busy low. Inserts and deletes shift the affected cells by one
// place at once, so they can follow one another every cycle while no read-out
// streams; each gives one result in the cycle after acceptance, with read_value
// zero. A read-all transaction raises busy during the read-out: the chain rotates
// the occupied cells by one each cycle and the head is shown on the result ports,
// front to back, last_of_run marking the final element; after count rotations
// the list is back in place. Read-all of an empty list gives one result with
// status "empty". Every result stands on the rsp_ ports for exactly one cycle
// with rsp_strobe high and must be taken then: there is no way to stall it.
module positional_list_engine_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [plec_pkg::REQ_W-1:0]         req_type,
   input  wire logic signed [plec_pkg::DATA_W-1:0] req_item_value,
   input  wire logic [plec_pkg::POS_W-1:0]         req_position,
   output logic                                    rsp_strobe,
   output logic [1:0]                              rsp_status,
   output logic signed [plec_pkg::DATA_W-1:0]      rsp_read_value,
   output logic [plec_pkg::COUNT_W-1:0]            rsp_element_count,
   output logic                                    rsp_last_of_run
);
   import plec_pkg::*;

   logic                     accept;
   sel_type                  cell_sel [CAPACITY];
   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   rsp_type                  rsp;

   // hold off new transactions while a read-out streams
   assign accept = start & ~busy;

   plec_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_type     (req_type),
      .req_position (req_position),
      .head_value   (cell_value[0]),
      .busy         (busy),
      .cell_sel     (cell_sel),
      .rsp          (rsp)
   );

   // chain of cells: each takes its left or right neighbour, the new value
   // or the head, as the controller selects
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [DATA_W-1:0] left_value;
      logic signed [DATA_W-1:0] right_value;

      if (g == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_inner_left
         assign left_value = cell_value[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_inner_right
         assign right_value = cell_value[g+1];
      end

      plec_cell u_cell (
         .clock       (clock),
         .sel         (cell_sel[g]),
         .left_value  (left_value),
         .right_value (right_value),
         .new_value   (req_item_value),
         .head_value  (cell_value[0]),
         .value       (cell_value[g])
      );
   end

   assign rsp_strobe        = rsp.strobe;
   assign rsp_status        = rsp.status;
   assign rsp_read_value    = rsp.value;
   assign rsp_element_count = rsp.count;
   assign rsp_last_of_run   = rsp.last;

endmodule
`default_nettype wire
